[sv/tllhp_pkg.sv]
package tllhp_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 1024;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int HIST_W        = 5;
  localparam int PAT_ENTRIES   = 1 << HIST_W;
  localparam int ADDR_W        = 64;
  localparam int CNT_W         = 32;

  // result kinds
  typedef enum logic [1:0] {
    KIND_CORRECT   = 2'd0,
    KIND_MISPRED   = 2'd1,
    KIND_COLLISION = 2'd2
  } kind_e;

  // resolved branch request
  typedef struct packed {
    logic [ADDR_W-1:0] branch_addr;
    logic              taken;
  } req_t;

  // per-branch result
  typedef struct packed {
    logic [1:0]       outcome_kind;
    logic             predicted_taken;
    logic [CNT_W-1:0] correct_total;
    logic [CNT_W-1:0] incorrect_total;
    logic [CNT_W-1:0] collision_total;
  } rsp_t;

  // first-level table entry
  typedef struct packed {
    logic [ADDR_W-1:0] tag;
    logic [HIST_W-1:0] hist;
  } entry_t;

endpackage

[sv/two_level_local_history_predictor.sv]
// result: a request is accepted in idle with a registered read of the
//   history/tag memory; its result is registered in the lookup state, which
//   waits there while the previous result is still stalled at the output
// requests: a new request is taken only in idle, after the lookup state has
//   written back the history/tag entry; reset: counters and pattern bits clear
//   at once, then the 1024-entry memory is swept to zero while in_stall_o stays high
module two_level_local_history_predictor (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tllhp_pkg::req_t  in_req_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output tllhp_pkg::rsp_t  out_rsp_o
);
  import tllhp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_LOOK  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [ADDR_W-1:0] addr_q;
  logic              taken_q;
  entry_t            mem_q [TABLE_ENTRIES];
  entry_t            rd_data_q;
  logic [IDX_W-1:0]  rd_addr;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic [PAT_ENTRIES-1:0] pat_q, pat_d;
  logic [CNT_W-1:0]  correct_q, correct_d;
  logic [CNT_W-1:0]  incorrect_q, incorrect_d;
  logic [CNT_W-1:0]  collision_q, collision_d;
  logic              out_valid_q, out_valid_d;
  rsp_t              out_rsp_q, out_rsp_d;
  logic              in_fire;
  logic              out_free;
  logic              step;
  logic              hit;
  logic [HIST_W-1:0] hist;
  logic              pbit;
  logic [HIST_W-1:0] hist_new;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign step        = (state_q == ST_LOOK) && out_free;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // read address: incoming request in idle, held request while looking up
  assign rd_addr = (state_q == ST_LOOK) ? addr_q[IDX_W-1:0]
                                        : in_req_i.branch_addr[IDX_W-1:0];

  // lookup decode
  assign hit      = (rd_data_q.tag == addr_q);
  assign hist     = rd_data_q.hist;
  assign pbit     = pat_q[hist];
  assign hist_new = {taken_q, hist[HIST_W-1:1]};

  // history/tag memory, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  // write port: clearing sweep or write-back of the looked-up entry
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = addr_q[IDX_W-1:0];
    mem_wdata = '0;
    if (state_q == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_q;
    end else if (step) begin
      mem_we        = 1'b1;
      mem_wdata.tag  = addr_q;
      mem_wdata.hist = hist_new;
    end
  end

  // control, pattern bits, counters and result
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    pat_d       = pat_q;
    correct_d   = correct_q;
    incorrect_d = incorrect_q;
    collision_d = collision_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rsp_d   = out_rsp_q;
    case (state_q)
      ST_CLEAR: begin
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (step) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          if (!hit) begin
            pat_d[hist] = taken_q;
            if (collision_q != '1) begin
              collision_d = collision_q + CNT_W'(1);
            end
            out_rsp_d.outcome_kind    = KIND_COLLISION;
            out_rsp_d.predicted_taken = 1'b0;
          end else if (pbit == taken_q) begin
            if (correct_q != '1) begin
              correct_d = correct_q + CNT_W'(1);
            end
            out_rsp_d.outcome_kind    = KIND_CORRECT;
            out_rsp_d.predicted_taken = pbit;
          end else begin
            pat_d[hist] = taken_q;
            if (incorrect_q != '1) begin
              incorrect_d = incorrect_q + CNT_W'(1);
            end
            out_rsp_d.outcome_kind    = KIND_MISPRED;
            out_rsp_d.predicted_taken = pbit;
          end
          out_rsp_d.correct_total   = correct_d;
          out_rsp_d.incorrect_total = incorrect_d;
          out_rsp_d.collision_total = collision_d;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pat_q       <= '0;
      correct_q   <= '0;
      incorrect_q <= '0;
      collision_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pat_q       <= pat_d;
      correct_q   <= correct_d;
      incorrect_q <= incorrect_d;
      collision_q <= collision_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      addr_q  <= in_req_i.branch_addr;
      taken_q <= in_req_i.taken;
    end
    out_rsp_q <= out_rsp_d;
  end

endmodule

[verif/tllhp_tb_pkg.sv]
package tllhp_tb_pkg;

  import tllhp_pkg::*;

  // tracks predictor state and checks every result in order
  class branch_scoreboard;

    bit [ADDR_W-1:0] tag_mem [TABLE_ENTRIES];
    bit [HIST_W-1:0] hist_mem [TABLE_ENTRIES];
    bit              pattern_mem [PAT_ENTRIES];
    bit [CNT_W-1:0]  n_correct;
    bit [CNT_W-1:0]  n_mispred;
    bit [CNT_W-1:0]  n_collide;
    rsp_t            expected_results [$];
    int              mismatch_count;

    // counters stick at all ones
    static function bit [CNT_W-1:0] bump(bit [CNT_W-1:0] v);
      return (v == '1) ? v : v + 1'b1;
    endfunction

    // apply one resolved branch and queue the result it should give
    function void note_branch(req_t r);
      bit [IDX_W-1:0]  idx;
      bit [HIST_W-1:0] h;
      rsp_t            want;
      idx  = IDX_W'(r.branch_addr % TABLE_ENTRIES);
      h    = hist_mem[idx];
      want = '0;
      if (tag_mem[idx] != r.branch_addr) begin
        tag_mem[idx]         = r.branch_addr;
        pattern_mem[h]       = r.taken;
        n_collide            = bump(n_collide);
        want.outcome_kind    = KIND_COLLISION;
        want.predicted_taken = 1'b0;
      end else begin
        want.predicted_taken = pattern_mem[h];
        if (pattern_mem[h] == r.taken) begin
          n_correct         = bump(n_correct);
          want.outcome_kind = KIND_CORRECT;
        end else begin
          pattern_mem[h]    = r.taken;
          n_mispred         = bump(n_mispred);
          want.outcome_kind = KIND_MISPRED;
        end
      end
      hist_mem[idx]        = {r.taken, h[HIST_W-1:1]};
      want.correct_total   = n_correct;
      want.incorrect_total = n_mispred;
      want.collision_total = n_collide;
      expected_results.push_back(want);
    endfunction

    // compare one accepted result with the oldest outstanding one
    function void check_result(rsp_t got);
      rsp_t want;
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: kind=%0d pred=%0d totals=%0d/%0d/%0d",
                   got.outcome_kind, got.predicted_taken, got.correct_total,
                   got.incorrect_total, got.collision_total);
        return;
      end
      want = expected_results.pop_front();
      if (got.outcome_kind !== want.outcome_kind ||
          got.predicted_taken !== want.predicted_taken ||
          got.correct_total !== want.correct_total ||
          got.incorrect_total !== want.incorrect_total ||
          got.collision_total !== want.collision_total) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("mismatch exp: kind=%0d pred=%0d totals=%0d/%0d/%0d",
                   want.outcome_kind, want.predicted_taken, want.correct_total,
                   want.incorrect_total, want.collision_total);
          $display("         got: kind=%0d pred=%0d totals=%0d/%0d/%0d",
                   got.outcome_kind, got.predicted_taken, got.correct_total,
                   got.incorrect_total, got.collision_total);
        end
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

  endclass

endpackage

[verif/tb.sv]
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import tllhp_pkg::*;
  import tllhp_tb_pkg::*;

  localparam int RANDOM_BRANCHES = 1750;
  localparam int POOL            = 48;
  localparam int IDLE_PCT        = 14;
  localparam int CYCLE_LIMIT     = 200000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  req_t in_req_i    = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  rsp_t out_rsp_o;

  branch_scoreboard sb = new();
  bit               quiet = 1'b0;
  int unsigned      cycle_count = 0;

  two_level_local_history_predictor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // random idle decision shared by both sides
  function automatic bit idle_roll();
    return !quiet && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // hold the request until the block takes it, with random gaps before it
  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    req_t r;
    r.branch_addr = addr;
    r.taken       = taken;
    while (idle_roll()) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_branch(in_req_i);
  endtask

  // stop sending until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // result side: check accepted results, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(out_rsp_o);
    out_stall_i <= idle_roll();
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [ADDR_W-1:0] pool_addr [POOL];
    logic [7:0]        pool_pattern [POOL];
    int                pool_period [POOL];
    int                pool_phase [POOL];
    int                sent;
    int                roll;
    int                p;
    int                run;
    bit                drained;

    // branch pool: some entries alias the index of their neighbor
    for (int i = 0; i < POOL; i++) begin
      if (i % 6 == 5)
        pool_addr[i] = {$urandom, 22'($urandom_range(4194303)), pool_addr[i-1][9:0]};
      else
        pool_addr[i] = {$urandom, $urandom};
      pool_pattern[i] = 8'($urandom_range(255));
      pool_period[i]  = $urandom_range(1, 6);
      pool_phase[i]   = 0;
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // address zero hits the cleared tags: correct, then two mispredictions
    send_branch(64'h0, 1'b0);
    send_branch(64'h0, 1'b1);
    send_branch(64'h0, 1'b1);
    // all-ones address collides, then hits
    send_branch('1, 1'b1);
    send_branch('1, 1'b0);
    // top bit only aliases index zero, then zero comes back as a collision
    send_branch(64'h8000_0000_0000_0000, 1'b0);
    send_branch(64'h0, 1'b0);
    send_branch(64'h0000_0000_0000_03FF, 1'b1);
    // short loop that the local history learns
    repeat (4) begin
      send_branch(64'hDEAD_BEEF_CAFE_1234, 1'b1);
      send_branch(64'hDEAD_BEEF_CAFE_1234, 1'b1);
      send_branch(64'hDEAD_BEEF_CAFE_1234, 1'b0);
    end
    drain();

    // random part: mostly pool branches following their own patterns
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_BRANCHES) begin
      quiet = (sent >= 600 && sent < 900);
      roll  = $urandom_range(99);
      if (roll < 80) begin
        p   = $urandom_range(POOL - 1);
        run = $urandom_range(1, 8);
        repeat (run) begin
          send_branch(pool_addr[p], pool_pattern[p][pool_phase[p]]);
          pool_phase[p] = (pool_phase[p] + 1) % pool_period[p];
          sent++;
        end
      end else if (roll < 90) begin
        send_branch({$urandom, $urandom}, 1'($urandom_range(1)));
        sent++;
      end else begin
        send_branch(pool_addr[$urandom_range(POOL - 1)], 1'($urandom_range(1)));
        sent++;
      end
      if (!drained && sent >= 1000) begin
        drain();
        drained = 1'b1;
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    // wait for the tail
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (8) @(posedge clk_i);
    if (sb.mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
